// File: design/wildcard_glob_matcher_assert.svh
// Assertion macros shared by the glob matcher RTL.
// No dependencies; the including module supplies clock and reset.
`ifndef WILDCARD_GLOB_MATCHER_ASSERT_SVH
`define WILDCARD_GLOB_MATCHER_ASSERT_SVH

// Whenever cond holds in a cycle, expr must hold in the same cycle.
`define WGM_ASSERT_SAME(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("glob matcher assertion failed");

// Whenever cond holds in a cycle, expr must hold in the following cycle.
`define WGM_ASSERT_NEXT(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("glob matcher assertion failed");

`endif

// File: design/wgm_pkg.sv
// Shared constants, types and the case-folding function of the glob matcher.
// No dependencies.
package wgm_pkg;

   localparam int MAX_PATTERN = 32;
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   localparam logic [1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [1:0] FUNC_APPEND  = 2'd1;
   localparam logic [1:0] FUNC_SUBJECT = 2'd2;
   localparam logic [1:0] FUNC_END     = 2'd3;

   localparam logic [7:0] STAR_CHAR  = 8'h2A;
   localparam logic [7:0] QMARK_CHAR = 8'h3F;

   typedef logic [MAX_PATTERN:0] vec_type;
   typedef logic [MAX_PATTERN-1:0][7:0] store_type;
   typedef logic [LEN_W-1:0] len_type;

   function automatic logic [7:0] fold_byte(input logic fold, input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (fold && (c inside {[8'h41:8'h5A]})) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

// File: design/wgm_step.sv
// One update of the active-position vector: star closure and subject byte step.
// Depends on wgm_pkg.
module wgm_step (
   input  wgm_pkg::vec_type   raw_vec,
   input  wgm_pkg::store_type pattern,
   input  wgm_pkg::len_type   pattern_len,
   input  logic               fold,
   input  logic [7:0]         character,
   output wgm_pkg::vec_type   next_raw_vec,
   output logic               end_hit
);
   import wgm_pkg::*;

   vec_type star_vec;
   vec_type gen_vec;
   vec_type sum_vec;
   vec_type closed_vec;
   vec_type move_vec;
   logic [MAX_PATTERN-1:0] in_pat;
   logic [7:0] subj_folded;

   assign subj_folded = fold_byte(fold, character);

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_pos
      assign in_pat[i]   = len_type'(i) < pattern_len;
      assign star_vec[i] = in_pat[i] && (pattern[i] == STAR_CHAR);
      assign move_vec[i + 1] = closed_vec[i] && in_pat[i] && !star_vec[i] &&
                               ((pattern[i] == QMARK_CHAR) ||
                                (fold_byte(fold, pattern[i]) == subj_folded));
   end
   assign star_vec[MAX_PATTERN] = 1'b0;
   assign move_vec[0] = 1'b0;

   // Closure over runs of stars is a carry chain: a star holding an active
   // position generates, a star without one propagates.
   assign gen_vec    = star_vec & raw_vec;
   assign sum_vec    = gen_vec + star_vec;
   assign closed_vec = raw_vec | (sum_vec ^ gen_vec ^ star_vec);

   assign next_raw_vec = move_vec | (closed_vec & star_vec);
   assign end_hit      = closed_vec[pattern_len];

endmodule

// File: design/wildcard_glob_matcher.sv
// Glob matcher top level. An end beat goes through the execute and response registers.
// One beat per cycle barring end-beat stalls; closure and byte step are combinational.
// An end beat waits in the execute register only while the previous result is untaken.
// Synchronous active-high reset empties the pipeline, clears the pattern length,
// overflow flag and case mode; the pattern store itself is not reset.
module wildcard_glob_matcher (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_func,
   input  logic [7:0] req_character,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_pattern_overflow,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_ignore_case
);
   import wgm_pkg::*;

   localparam vec_type START_VEC = vec_type'(1);

   logic       exe_valid_ff, exe_valid_in;
   logic [1:0] exe_func_ff;
   logic [7:0] exe_char_ff;
   logic       exe_fire;

   store_type  store_ff;
   len_type    len_ff, len_in;
   vec_type    raw_ff, raw_in;
   logic       overflow_ff, overflow_in;
   logic       fold_ff;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_matched_ff, rsp_overflow_ff;

   vec_type    step_vec;
   logic       end_hit;
   logic       store_write;

   wgm_step u_step (
      .raw_vec      (raw_ff),
      .pattern      (store_ff),
      .pattern_len  (len_ff),
      .fold         (fold_ff),
      .character    (exe_char_ff),
      .next_raw_vec (step_vec),
      .end_hit      (end_hit)
   );

   assign exe_fire = exe_valid_ff &&
                     ((exe_func_ff != FUNC_END) || !rsp_valid_ff || rsp_ready);
   assign req_ready    = !exe_valid_ff || exe_fire;
   assign exe_valid_in = req_ready ? req_valid : exe_valid_ff;
   assign store_write  = exe_fire && (exe_func_ff == FUNC_APPEND) &&
                         (len_ff < len_type'(MAX_PATTERN));

   always_comb begin
      len_in      = len_ff;
      raw_in      = raw_ff;
      overflow_in = overflow_ff;
      if (exe_fire) begin
         case (exe_func_ff)
            FUNC_CLEAR: begin
               len_in      = '0;
               overflow_in = 1'b0;
               raw_in      = START_VEC;
            end
            FUNC_APPEND: begin
               if (len_ff < len_type'(MAX_PATTERN)) begin
                  len_in = len_ff + len_type'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               raw_in = START_VEC;
            end
            FUNC_SUBJECT: begin
               raw_in = step_vec;
            end
            default: begin
               raw_in = START_VEC;
            end
         endcase
      end
   end

   assign rsp_valid_in = (exe_fire && (exe_func_ff == FUNC_END)) ||
                         (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         exe_valid_ff <= 1'b0;
         len_ff       <= '0;
         raw_ff       <= START_VEC;
         overflow_ff  <= 1'b0;
         fold_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         exe_valid_ff <= exe_valid_in;
         len_ff       <= len_in;
         raw_ff       <= raw_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            fold_ff <= csr_ignore_case;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         exe_func_ff <= req_func;
         exe_char_ff <= req_character;
      end
      if (store_write) begin
         store_ff[len_ff[IDX_W-1:0]] <= exe_char_ff;
      end
      if (exe_fire && (exe_func_ff == FUNC_END)) begin
         rsp_matched_ff  <= end_hit && !overflow_ff;
         rsp_overflow_ff <= overflow_ff;
      end
   end

   assign csr_ready            = 1'b1;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_matched          = rsp_matched_ff;
   assign rsp_pattern_overflow = rsp_overflow_ff;

`include "wildcard_glob_matcher_assert.svh"

   `WGM_ASSERT_SAME(a_len_bound, 1'b1, len_ff <= len_type'(MAX_PATTERN))
   `WGM_ASSERT_SAME(a_overflow_full, overflow_ff, len_ff == len_type'(MAX_PATTERN))
   `WGM_ASSERT_SAME(a_match_no_overflow, rsp_valid && rsp_matched, !rsp_pattern_overflow)
   `WGM_ASSERT_NEXT(a_end_restarts, exe_fire && (exe_func_ff == FUNC_END), raw_ff == START_VEC)

endmodule
